>>> rtl/pfvu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfvu_pkg - shared constants and types for the particle velocity update
// Register map, fixed-point widths and the lane control bundle.
// ----------------------------------------------------------------------------
package pfvu_pkg;

   localparam int VEC_BITS_DEF = 20;     // default vector component width
   localparam int CFG_W        = 60;     // width of a packed vector register
   localparam int CSR_ADDR_W   = 3;
   localparam int DT_W         = 16;     // time step, unsigned Q0.16
   localparam int DRAG_W       = 16;     // drag rate, unsigned Q4.12
   localparam int DRAG_FRAC    = 12;
   localparam int MODE_W       = 2;
   localparam int FACTOR_W     = 17;     // drag factor, unsigned Q1.16
   localparam int STAGES       = 4;

   localparam logic [FACTOR_W-1:0] ONE_Q16 = 17'h10000;

   localparam int MODE_ENABLE_BIT = 0;
   localparam int MODE_FIELD_BIT  = 1;

   // register indices
   localparam logic [CSR_ADDR_W-1:0] REG_GRAVITY = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_WIND    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_FIELD   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_BOX_MIN = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_BOX_MAX = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_DRAG    = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_MODE    = 3'd6;

   typedef struct packed {
      logic [CFG_W-1:0]  gravity;
      logic [CFG_W-1:0]  wind;
      logic [CFG_W-1:0]  field_accel;
      logic [CFG_W-1:0]  box_min;
      logic [CFG_W-1:0]  box_max;
      logic [DRAG_W-1:0] drag_rate;
      logic [MODE_W-1:0] mode;
   } csr_regs_type;

   // control handed from the sequencing logic to every lane
   typedef struct packed {
      logic [STAGES-1:0]   adv;       // per-stage load enable
      logic                accel_on;  // gravity and wind applied
      logic                drag_on;   // drag scaling applied
      logic [FACTOR_W-1:0] factor;    // drag factor for the item in stage 2
      logic                hit;       // field hit for the item in stage 3
   } lane_ctl_type;

endpackage

>>> rtl/pfvu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfvu_if - channel interfaces of the particle velocity update
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface pfvu_req_if #(
   parameter int VEC_BITS = pfvu_pkg::VEC_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [VEC_BITS-1:0]    vel_x;
   logic signed [VEC_BITS-1:0]    vel_y;
   logic signed [VEC_BITS-1:0]    vel_z;
   logic signed [VEC_BITS-1:0]    pos_x;
   logic signed [VEC_BITS-1:0]    pos_y;
   logic signed [VEC_BITS-1:0]    pos_z;
   logic [pfvu_pkg::DT_W-1:0]     time_step;

   modport source (output valid, vel_x, vel_y, vel_z, pos_x, pos_y, pos_z, time_step,
                   input ready);
   modport sink   (input valid, vel_x, vel_y, vel_z, pos_x, pos_y, pos_z, time_step,
                   output ready);
endinterface

interface pfvu_rsp_if #(
   parameter int VEC_BITS = pfvu_pkg::VEC_BITS_DEF
);
   logic                       valid;
   logic                       ready;
   logic signed [VEC_BITS-1:0] new_vel_x;
   logic signed [VEC_BITS-1:0] new_vel_y;
   logic signed [VEC_BITS-1:0] new_vel_z;
   logic                       in_field;

   modport source (output valid, new_vel_x, new_vel_y, new_vel_z, in_field, input ready);
   modport sink   (input valid, new_vel_x, new_vel_y, new_vel_z, in_field, output ready);
endinterface

interface pfvu_csr_if;
   logic                            valid;
   logic                            ready;
   logic [pfvu_pkg::CSR_ADDR_W-1:0] addr;
   logic [pfvu_pkg::CFG_W-1:0]      data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

>>> rtl/pfvu_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfvu_csr - configuration register file
// Always ready; unknown indices are dropped.
// ----------------------------------------------------------------------------
module pfvu_csr (
   input  logic                   clock,
   input  logic                   reset,
   pfvu_csr_if.sink               csr_chan,
   output pfvu_pkg::csr_regs_type regs
);

   pfvu_pkg::csr_regs_type regs_ff, regs_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      regs_in = regs_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.addr)
            pfvu_pkg::REG_GRAVITY: regs_in.gravity     = csr_chan.data;
            pfvu_pkg::REG_WIND:    regs_in.wind        = csr_chan.data;
            pfvu_pkg::REG_FIELD:   regs_in.field_accel = csr_chan.data;
            pfvu_pkg::REG_BOX_MIN: regs_in.box_min     = csr_chan.data;
            pfvu_pkg::REG_BOX_MAX: regs_in.box_max     = csr_chan.data;
            pfvu_pkg::REG_DRAG:    regs_in.drag_rate   = csr_chan.data[pfvu_pkg::DRAG_W-1:0];
            pfvu_pkg::REG_MODE:    regs_in.mode        = csr_chan.data[pfvu_pkg::MODE_W-1:0];
            default:               regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '0;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign regs = regs_ff;

endmodule

>>> rtl/pfvu_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfvu_lane - one axis of the velocity update datapath
// Four stages: dt products, gravity/wind add, drag product, drag + field.
// ----------------------------------------------------------------------------
module pfvu_lane #(
   parameter int VEC_BITS = pfvu_pkg::VEC_BITS_DEF
) (
   input  logic                       clock,
   input  pfvu_pkg::lane_ctl_type     ctl,
   input  logic signed [VEC_BITS-1:0] vel,
   input  logic signed [VEC_BITS-1:0] pos,
   input  logic [pfvu_pkg::DT_W-1:0]  time_step,
   input  logic signed [VEC_BITS-1:0] grav,
   input  logic signed [VEC_BITS-1:0] wind,
   input  logic signed [VEC_BITS-1:0] fld,
   input  logic signed [VEC_BITS-1:0] box_min,
   input  logic signed [VEC_BITS-1:0] box_max,
   output logic                       in_range,
   output logic signed [VEC_BITS-1:0] new_vel
);

   localparam int DT_W = pfvu_pkg::DT_W;
   localparam int PW   = VEC_BITS + DT_W + 1;                  // a * dt
   localparam int SW   = VEC_BITS + 1;                         // scaled a*dt
   localparam int DPW  = VEC_BITS + pfvu_pkg::FACTOR_W + 1;    // v * factor

   localparam logic signed [DPW-1:0] V_MAX =
      {{(DPW-VEC_BITS+1){1'b0}}, {(VEC_BITS-1){1'b1}}};
   localparam logic signed [DPW-1:0] V_MIN = ~V_MAX;

   function automatic logic signed [VEC_BITS-1:0] sat_v(input logic signed [DPW-1:0] x);
      logic signed [VEC_BITS-1:0] r;
      if (x > V_MAX) begin
         r = V_MAX[VEC_BITS-1:0];
      end else if (x < V_MIN) begin
         r = V_MIN[VEC_BITS-1:0];
      end else begin
         r = x[VEC_BITS-1:0];
      end
      return r;
   endfunction

   logic signed [DT_W:0] dt_s;

   // stage 1
   logic signed [VEC_BITS-1:0] vel1_ff;
   logic signed [PW-1:0]       gp1_ff, gp1_in, wp1_ff, wp1_in, fp1_ff, fp1_in;
   logic                       inr1_ff, inr1_in;
   // stage 2
   logic signed [VEC_BITS-1:0] vel2_ff, vel2_in;
   logic signed [SW-1:0]       fs2_ff;
   logic signed [VEC_BITS-1:0] vel_g;
   // stage 3
   logic signed [VEC_BITS-1:0] vel3_ff;
   logic signed [SW-1:0]       fs3_ff;
   logic signed [DPW-1:0]      prod3_ff, prod3_in;
   // stage 4
   logic signed [VEC_BITS-1:0] vel4_ff, vel4_in;
   logic signed [VEC_BITS-1:0] vel_d;

   assign dt_s = $signed({1'b0, time_step});

   assign gp1_in  = PW'(grav) * PW'(dt_s);
   assign wp1_in  = PW'(wind) * PW'(dt_s);
   assign fp1_in  = PW'(fld) * PW'(dt_s);
   assign inr1_in = (pos >= box_min) && (pos <= box_max);

   // floor(a*dt / 2^16) is the upper slice of the product
   always_comb begin
      vel_g = sat_v(DPW'(vel1_ff) + DPW'($signed(gp1_ff[PW-1:DT_W])));
      if (ctl.accel_on) begin
         vel2_in = sat_v(DPW'(vel_g) + DPW'($signed(wp1_ff[PW-1:DT_W])));
      end else begin
         vel2_in = vel1_ff;
      end
   end

   assign prod3_in = DPW'(vel2_ff) * DPW'($signed({1'b0, ctl.factor}));

   always_comb begin
      if (ctl.drag_on) begin
         vel_d = sat_v(prod3_ff >>> DT_W);
      end else begin
         vel_d = vel3_ff;
      end
      if (ctl.hit) begin
         vel4_in = sat_v(DPW'(vel_d) + DPW'(fs3_ff));
      end else begin
         vel4_in = vel_d;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv[0]) begin
         vel1_ff <= vel;
         gp1_ff  <= gp1_in;
         wp1_ff  <= wp1_in;
         fp1_ff  <= fp1_in;
         inr1_ff <= inr1_in;
      end
      if (ctl.adv[1]) begin
         vel2_ff <= vel2_in;
         fs2_ff  <= $signed(fp1_ff[PW-1:DT_W]);
      end
      if (ctl.adv[2]) begin
         vel3_ff  <= vel2_ff;
         fs3_ff   <= fs2_ff;
         prod3_ff <= prod3_in;
      end
      if (ctl.adv[3]) begin
         vel4_ff <= vel4_in;
      end
   end

   assign in_range = inr1_ff;
   assign new_vel  = vel4_ff;

endmodule

>>> rtl/pfvu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfvu_ctrl - pipeline sequencing, drag factor and field hit merge
// Bubble-collapsing valid chain; merges the per-lane box tests.
// ----------------------------------------------------------------------------
module pfvu_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [pfvu_pkg::DT_W-1:0]     time_step,
   input  pfvu_pkg::csr_regs_type        regs,
   input  logic [2:0]                    lane_in_range,
   output logic                          in_field,
   output pfvu_pkg::lane_ctl_type        ctl
);

   localparam int STAGES = pfvu_pkg::STAGES;
   localparam int DD_W   = pfvu_pkg::DRAG_W + pfvu_pkg::DT_W;
   localparam int DS_W   = DD_W - pfvu_pkg::DRAG_FRAC;

   logic [STAGES-1:0]                vld_ff, vld_in;
   logic [STAGES-1:0]                adv;
   logic [DD_W-1:0]                  dd1_ff;
   logic [DS_W-1:0]                  dd_sh;
   logic [pfvu_pkg::FACTOR_W-1:0]    factor2_ff, factor2_in;
   logic                             hit2_ff, hit2_in, hit3_ff, hit4_ff;
   logic                             enabled;

   assign enabled = regs.mode[pfvu_pkg::MODE_ENABLE_BIT];

   // a stage may load when it is empty or its content moves on
   always_comb begin
      adv[STAGES-1] = !vld_ff[STAGES-1] || rsp_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   always_comb begin
      vld_in[0] = req_valid;
      for (int k = 1; k < STAGES; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   // factor = max(0, 1 - drag*dt) in Q1.16
   assign dd_sh = dd1_ff[DD_W-1:pfvu_pkg::DRAG_FRAC];
   always_comb begin
      if (dd_sh > DS_W'(pfvu_pkg::ONE_Q16)) begin
         factor2_in = '0;
      end else begin
         factor2_in = pfvu_pkg::ONE_Q16 - dd_sh[pfvu_pkg::FACTOR_W-1:0];
      end
   end

   assign hit2_in = enabled && regs.mode[pfvu_pkg::MODE_FIELD_BIT] && (&lane_in_range);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         dd1_ff <= DD_W'(regs.drag_rate) * DD_W'(time_step);
      end
      if (adv[1]) begin
         factor2_ff <= factor2_in;
         hit2_ff    <= hit2_in;
      end
      if (adv[2]) begin
         hit3_ff <= hit2_ff;
      end
      if (adv[3]) begin
         hit4_ff <= hit3_ff;
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = vld_ff[STAGES-1];
   assign in_field  = hit4_ff;

   assign ctl.adv      = adv;
   assign ctl.accel_on = enabled;
   assign ctl.drag_on  = enabled && (regs.drag_rate != '0);
   assign ctl.factor   = factor2_ff;
   assign ctl.hit      = hit3_ff;

endmodule

>>> rtl/particle_force_velocity_update_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_force_velocity_update_unit - Euler velocity step with drag and field
// The response is valid once the request has passed all four lane stages.
// Throughput: one transaction per cycle, set by the four-stage lane pipeline;
// stalls on the response side fill bubbles before back-pressure reaches req.
// Reset (synchronous, active high) empties the pipeline and clears the register file.
// ----------------------------------------------------------------------------
module particle_force_velocity_update_unit #(
   parameter int VEC_BITS = pfvu_pkg::VEC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   pfvu_req_if.sink   req_chan,
   pfvu_rsp_if.source rsp_chan,
   pfvu_csr_if.sink   csr_chan
);

   localparam int CFG_W  = pfvu_pkg::CFG_W;
   localparam int PACK_W = 3 * VEC_BITS;

   pfvu_pkg::csr_regs_type regs;
   pfvu_pkg::lane_ctl_type ctl;

   // Register contents widened or trimmed to three components; bits of the
   // top component above the 60-bit register read as zero.
   logic [PACK_W+CFG_W-1:0] grav_w, wind_w, fld_w, bmin_w, bmax_w;

   logic signed [VEC_BITS-1:0] vel_a [3];
   logic signed [VEC_BITS-1:0] pos_a [3];
   logic signed [VEC_BITS-1:0] out_a [3];
   logic [2:0]                 in_range;

   assign grav_w = {{PACK_W{1'b0}}, regs.gravity};
   assign wind_w = {{PACK_W{1'b0}}, regs.wind};
   assign fld_w  = {{PACK_W{1'b0}}, regs.field_accel};
   assign bmin_w = {{PACK_W{1'b0}}, regs.box_min};
   assign bmax_w = {{PACK_W{1'b0}}, regs.box_max};

   assign vel_a[0] = req_chan.vel_x;
   assign vel_a[1] = req_chan.vel_y;
   assign vel_a[2] = req_chan.vel_z;
   assign pos_a[0] = req_chan.pos_x;
   assign pos_a[1] = req_chan.pos_y;
   assign pos_a[2] = req_chan.pos_z;

   pfvu_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .regs     (regs)
   );

   // Sequencing: valid chain, drag factor and the merge of the box tests
   pfvu_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .time_step     (req_chan.time_step),
      .regs          (regs),
      .lane_in_range (in_range),
      .in_field      (rsp_chan.in_field),
      .ctl           (ctl)
   );

   // One lane per axis, all driven by the same stage enables
   for (genvar i = 0; i < 3; i++) begin : g_lane
      pfvu_lane #(
         .VEC_BITS (VEC_BITS)
      ) u_lane (
         .clock     (clock),
         .ctl       (ctl),
         .vel       (vel_a[i]),
         .pos       (pos_a[i]),
         .time_step (req_chan.time_step),
         .grav      ($signed(grav_w[i*VEC_BITS +: VEC_BITS])),
         .wind      ($signed(wind_w[i*VEC_BITS +: VEC_BITS])),
         .fld       ($signed(fld_w[i*VEC_BITS +: VEC_BITS])),
         .box_min   ($signed(bmin_w[i*VEC_BITS +: VEC_BITS])),
         .box_max   ($signed(bmax_w[i*VEC_BITS +: VEC_BITS])),
         .in_range  (in_range[i]),
         .new_vel   (out_a[i])
      );
   end

   assign rsp_chan.new_vel_x = out_a[0];
   assign rsp_chan.new_vel_y = out_a[1];
   assign rsp_chan.new_vel_z = out_a[2];

endmodule

>>> rtl/pfvu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfvu_checker - port-level checks of the particle velocity update
// Tracks transactions in flight and checks their count against pipeline depth.
// ----------------------------------------------------------------------------
module pfvu_checker #(
   parameter int VEC_BITS = pfvu_pkg::VEC_BITS_DEF
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [VEC_BITS-1:0] rsp_new_vel_x,
   input logic                       rsp_in_field
);

   localparam int CNT_W = $clog2(pfvu_pkg::STAGES + 1);

   logic [CNT_W-1:0] inflight_ff, inflight_in;
   logic             req_acc, rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      inflight_in = inflight_ff;
      if (req_acc && !rsp_acc) begin
         inflight_in = inflight_ff + 1'b1;
      end else if (rsp_acc && !req_acc) begin
         inflight_in = inflight_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   a_depth : assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= CNT_W'(pfvu_pkg::STAGES))
      else $error("more transactions in flight than pipeline stages");

   a_no_orphan : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (inflight_ff != '0))
      else $error("response without an outstanding request");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response withdrawn while stalled");

   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_new_vel_x) && $stable(rsp_in_field)))
      else $error("response payload changed while stalled");

endmodule

bind particle_force_velocity_update_unit pfvu_checker #(
   .VEC_BITS (VEC_BITS)
) u_pfvu_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_new_vel_x (rsp_chan.new_vel_x),
   .rsp_in_field  (rsp_chan.in_field)
);

>>> tb/particle_force_velocity_update_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_force_velocity_update_unit_tb - self-checking bench for the unit
// Drives particle transactions and register writes with random idling on both
// channels, predicts each updated velocity in fixed point and checks every
// response field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module particle_force_velocity_update_unit_tb;

   localparam int VB          = pfvu_pkg::VEC_BITS_DEF;
   localparam int CW          = pfvu_pkg::CFG_W;
   localparam int AW          = pfvu_pkg::CSR_ADDR_W;
   localparam int DTW         = pfvu_pkg::DT_W;
   localparam int DRW         = pfvu_pkg::DRAG_W;
   localparam int MW          = pfvu_pkg::MODE_W;
   localparam int VMAX        = (1 << (VB - 1)) - 1;
   localparam int VMIN        = -(1 << (VB - 1));
   localparam int PIPE_LAT    = pfvu_pkg::STAGES;
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 10;

   // index 7 is not decoded by the unit, writes to it must be dropped
   localparam logic [AW-1:0] REG_UNUSED = AW'(7);

   localparam logic [MW-1:0] MODE_OFF        = '0;
   localparam logic [MW-1:0] MODE_ENABLED    = MW'(1 << pfvu_pkg::MODE_ENABLE_BIT);
   localparam logic [MW-1:0] MODE_FIELD_ONLY = MW'(1 << pfvu_pkg::MODE_FIELD_BIT);
   localparam logic [MW-1:0] MODE_ALL        = MODE_ENABLED | MODE_FIELD_ONLY;

   typedef struct packed {
      logic [2:0][VB-1:0] vel;
      logic [2:0][VB-1:0] pos;
      logic [DTW-1:0]     dt;
   } particle_type;

   typedef struct packed {
      logic [2:0][VB-1:0] vel;
      logic               hit;
   } vel_result_type;

   logic clock;
   logic reset;

   pfvu_req_if #(.VEC_BITS(VB)) req_chan ();
   pfvu_rsp_if #(.VEC_BITS(VB)) rsp_chan ();
   pfvu_csr_if                  csr_chan ();

   particle_force_velocity_update_unit #(.VEC_BITS(VB)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // shadow of the register file, updated on each accepted write transaction
   pfvu_pkg::csr_regs_type force_cfg;

   vel_result_type pending_velocity_q[$];

   bit idle_enable;
   int stall_left;
   int mismatch_count;
   int items_sent;
   int results_checked;
   int csr_writes;
   int settings_used;
   int cycle_count;

   // -------------------------------------------------------------------------
   // Clock and watchdog
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("run stopped by the watchdog after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Fixed-point prediction
   // -------------------------------------------------------------------------
   function automatic longint sx(logic [VB-1:0] x);
      logic signed [VB-1:0] s;
      s = x;
      return longint'(s);
   endfunction

   function automatic longint lane(logic [CW-1:0] pk, int i);
      return sx(pk[i*VB +: VB]);
   endfunction

   function automatic longint clamp_vec(longint v);
      if (v > VMAX) return VMAX;
      if (v < VMIN) return VMIN;
      return v;
   endfunction

   // a*dt is Q10.26, arithmetic shift gives the floored Q10.10 value
   function automatic longint scale_dt(longint a, longint dt);
      return (a * dt) >>> DTW;
   endfunction

   function automatic vel_result_type predict_velocity(particle_type p);
      longint         v[3];
      longint         dt;
      longint         dd;
      longint         f;
      longint         t;
      logic           hit;
      vel_result_type r;
      dt  = longint'(p.dt);
      hit = 1'b0;
      for (int i = 0; i < 3; i++) v[i] = sx(p.vel[i]);
      if (force_cfg.mode[pfvu_pkg::MODE_ENABLE_BIT]) begin
         // gravity first, then wind, each saturated on its own
         for (int i = 0; i < 3; i++) begin
            v[i] = clamp_vec(v[i] + scale_dt(lane(force_cfg.gravity, i), dt));
            v[i] = clamp_vec(v[i] + scale_dt(lane(force_cfg.wind, i), dt));
         end
         if (force_cfg.drag_rate != '0) begin
            // Q4.12 * Q0.16 -> Q4.16, factor clamped at zero
            dd = (longint'(force_cfg.drag_rate) * dt) >>> pfvu_pkg::DRAG_FRAC;
            f  = longint'(pfvu_pkg::ONE_Q16) - dd;
            if (f < 0) f = 0;
            for (int i = 0; i < 3; i++) v[i] = clamp_vec((v[i] * f) >>> DTW);
         end
         if (force_cfg.mode[pfvu_pkg::MODE_FIELD_BIT]) begin
            // box bounds are inclusive on every axis
            hit = 1'b1;
            for (int i = 0; i < 3; i++)
               if (sx(p.pos[i]) < lane(force_cfg.box_min, i) ||
                   sx(p.pos[i]) > lane(force_cfg.box_max, i))
                  hit = 1'b0;
            if (hit)
               for (int i = 0; i < 3; i++)
                  v[i] = clamp_vec(v[i] + scale_dt(lane(force_cfg.field_accel, i), dt));
         end
      end
      for (int i = 0; i < 3; i++) begin
         t        = v[i];
         r.vel[i] = t[VB-1:0];
      end
      r.hit = hit;
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function automatic logic [CW-1:0] pack3(int x, int y, int z);
      logic [CW-1:0] pk;
      pk             = '0;
      pk[0 +: VB]    = x[VB-1:0];
      pk[VB +: VB]   = y[VB-1:0];
      pk[2*VB +: VB] = z[VB-1:0];
      return pk;
   endfunction

   // component with weight on the extremes and on small magnitudes
   function automatic int rand_comp();
      logic [VB-1:0] raw;
      raw = VB'($urandom);
      case ($urandom_range(0, 7))
         0:       return VMAX;
         1:       return VMIN;
         2, 3:    return int'($urandom_range(0, 4096)) - 2048;
         default: return int'(sx(raw));
      endcase
   endfunction

   // draws a particle, mostly inside the current box when it is not empty
   function automatic particle_type rand_particle();
      particle_type p;
      longint       lo;
      longint       hi;
      longint       pv;
      int           c;
      for (int i = 0; i < 3; i++) begin
         c        = rand_comp();
         p.vel[i] = c[VB-1:0];
         lo = lane(force_cfg.box_min, i);
         hi = lane(force_cfg.box_max, i);
         if (lo <= hi && $urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 7))
               0:       p.pos[i] = lo[VB-1:0];
               1:       p.pos[i] = hi[VB-1:0];
               default: begin
                  pv       = lo + longint'($urandom_range(0, int'(hi - lo)));
                  p.pos[i] = pv[VB-1:0];
               end
            endcase
         end else begin
            c        = rand_comp();
            p.pos[i] = c[VB-1:0];
         end
      end
      case ($urandom_range(0, 7))
         0:       p.dt = '0;
         1:       p.dt = '1;
         2:       p.dt = DTW'($urandom_range(0, 255));
         default: p.dt = DTW'($urandom);
      endcase
      return p;
   endfunction

   // drops req valid and waits until every outstanding result has come back
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (pending_velocity_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [AW-1:0] idx,
                            input logic [CW-1:0] value);
      wait_idle();
      csr_chan.valid <= 1'b1;
      csr_chan.addr  <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      @(posedge clock);
      csr_writes++;
      case (idx)
         pfvu_pkg::REG_GRAVITY: force_cfg.gravity     = value;
         pfvu_pkg::REG_WIND:    force_cfg.wind        = value;
         pfvu_pkg::REG_FIELD:   force_cfg.field_accel = value;
         pfvu_pkg::REG_BOX_MIN: force_cfg.box_min     = value;
         pfvu_pkg::REG_BOX_MAX: force_cfg.box_max     = value;
         pfvu_pkg::REG_DRAG:    force_cfg.drag_rate   = value[DRW-1:0];
         pfvu_pkg::REG_MODE:    force_cfg.mode        = value[MW-1:0];
         default: ;
      endcase
   endtask

   // one particle transaction; valid is left high so back-to-back items flow
   task automatic send_item(input particle_type p);
      int gap;
      gap = idle_enable ? int'($urandom_range(0, 9)) : 0;
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.vel_x     <= p.vel[0];
      req_chan.vel_y     <= p.vel[1];
      req_chan.vel_z     <= p.vel[2];
      req_chan.pos_x     <= p.pos[0];
      req_chan.pos_y     <= p.pos[1];
      req_chan.pos_z     <= p.pos[2];
      req_chan.time_step <= p.dt;
      do @(posedge clock); while (!req_chan.ready);
      pending_velocity_q.push_back(predict_velocity(p));
      items_sent++;
   endtask

   task automatic send_particle(input int vx, vy, vz, px, py, pz, input int dt);
      particle_type p;
      p.vel[0] = vx[VB-1:0];
      p.vel[1] = vy[VB-1:0];
      p.vel[2] = vz[VB-1:0];
      p.pos[0] = px[VB-1:0];
      p.pos[1] = py[VB-1:0];
      p.pos[2] = pz[VB-1:0];
      p.dt     = dt[DTW-1:0];
      send_item(p);
   endtask

   task automatic report_mismatch(input string what, input longint want, input longint got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("[%0t] mismatch on %s, result %0d: expected %0d, got %0d",
                  $time, what, results_checked, want, got);
   endtask

   // -------------------------------------------------------------------------
   // Response side: check each accepted transaction, then draw the next stall
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      vel_result_type want;
      vel_result_type got;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.vel[0] = rsp_chan.new_vel_x;
            got.vel[1] = rsp_chan.new_vel_y;
            got.vel[2] = rsp_chan.new_vel_z;
            got.hit    = rsp_chan.in_field;
            if (pending_velocity_q.size() == 0) begin
               report_mismatch("unexpected response", 0, 1);
            end else begin
               want = pending_velocity_q.pop_front();
               if (got.vel[0] !== want.vel[0])
                  report_mismatch("new_vel_x", sx(want.vel[0]), sx(got.vel[0]));
               if (got.vel[1] !== want.vel[1])
                  report_mismatch("new_vel_y", sx(want.vel[1]), sx(got.vel[1]));
               if (got.vel[2] !== want.vel[2])
                  report_mismatch("new_vel_z", sx(want.vel[2]), sx(got.vel[2]));
               if (got.hit !== want.hit)
                  report_mismatch("in_field", longint'(want.hit), longint'(got.hit));
            end
            results_checked++;
            stall_left = idle_enable ? int'($urandom_range(0, 9)) : 0;
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_chan.ready <= (stall_left == 0);
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // reset state, then forces loaded but the enable bit clear
   task automatic test_disabled_passthrough();
      send_particle(VMAX, VMIN, 0, 0, 0, 0, 65535);
      csr_write(pfvu_pkg::REG_GRAVITY, pack3(VMAX, VMIN, 1024));
      csr_write(pfvu_pkg::REG_MODE, CW'(MODE_OFF));
      send_particle(VMIN, VMAX, -1, VMIN, VMAX, -1, 65535);
      send_particle(1, -1, 12345, 0, 0, 0, 32768);
      settings_used += 2;
   endtask

   // saturation on both rails, zero and tiny steps, floor on negative products
   task automatic test_gravity_and_wind();
      csr_write(pfvu_pkg::REG_WIND, pack3(VMAX, VMIN, -3));
      csr_write(pfvu_pkg::REG_DRAG, '0);
      csr_write(pfvu_pkg::REG_MODE, CW'(MODE_ENABLED));
      send_particle(VMAX, VMIN, 0, 0, 0, 0, 65535);
      send_particle(VMIN, VMAX, -1, 0, 0, 0, 65535);
      send_particle(5, 5, 5, 0, 0, 0, 0);
      send_particle(0, 0, 0, 0, 0, 0, 1);
      send_particle(-1, 1, 0, 0, 0, 0, 32768);
      settings_used++;
   endtask

   // factor clamped to zero, a quarter of drag, factor of one at dt zero
   task automatic test_drag_scaling();
      csr_write(pfvu_pkg::REG_GRAVITY, '0);
      csr_write(pfvu_pkg::REG_WIND, '0);
      csr_write(pfvu_pkg::REG_DRAG, CW'(16'hFFFF));
      send_particle(VMAX, VMIN, -7, 0, 0, 0, 65535);
      csr_write(pfvu_pkg::REG_DRAG, CW'(16'd4096));
      send_particle(VMAX, VMIN, -3, 0, 0, 0, 16384);
      send_particle(-1, 1, -1, 0, 0, 0, 65535);
      send_particle(VMIN, VMAX, 12345, 0, 0, 0, 0);
      settings_used += 2;
   endtask

   // inclusive bounds, one past each bound, empty box, field without enable
   task automatic test_field_box();
      csr_write(pfvu_pkg::REG_DRAG, '0);
      csr_write(pfvu_pkg::REG_FIELD, pack3(VMAX, VMIN, 512));
      csr_write(pfvu_pkg::REG_BOX_MIN, pack3(-1024, -1024, -1024));
      csr_write(pfvu_pkg::REG_BOX_MAX, pack3(1024, 1024, 1024));
      csr_write(pfvu_pkg::REG_MODE, CW'(MODE_ALL));
      send_particle(0, 0, 0, -1024, -1024, -1024, 65535);
      send_particle(100, -100, VMAX, 1024, 1024, 1024, 4096);
      send_particle(0, 0, 0, -1025, 0, 0, 65535);
      send_particle(0, 0, 0, 0, 0, 1025, 65535);
      // zero step inside the box still flags the hit
      send_particle(7, -7, 7, 0, 0, 0, 0);
      send_particle(0, 0, 0, VMIN, VMAX, 0, 65535);
      // min above max on x: nothing can be inside
      csr_write(pfvu_pkg::REG_BOX_MIN, pack3(2048, -1024, -1024));
      send_particle(0, 0, 0, 1024, 0, 0, 65535);
      csr_write(pfvu_pkg::REG_MODE, CW'(MODE_FIELD_ONLY));
      csr_write(pfvu_pkg::REG_BOX_MIN, pack3(-1024, -1024, -1024));
      send_particle(0, 0, 0, 0, 0, 0, 65535);
      // box spanning the full range
      csr_write(pfvu_pkg::REG_BOX_MIN, pack3(VMIN, VMIN, VMIN));
      csr_write(pfvu_pkg::REG_BOX_MAX, pack3(VMAX, VMAX, VMAX));
      csr_write(pfvu_pkg::REG_MODE, CW'(MODE_ALL));
      send_particle(1, 1, 1, VMIN, VMIN, VMIN, 65535);
      send_particle(-1, -1, -1, VMAX, VMAX, VMAX, 65535);
      settings_used += 4;
   endtask

   task automatic test_unknown_register();
      csr_write(REG_UNUSED, '1);
      send_particle(0, 0, 0, 0, 0, 0, 65535);
      send_particle(VMIN, VMAX, 0, -5, 5, 0, 1000);
   endtask

   // phases of random settings, the first two at the extremes
   task automatic test_random_traffic(input int phases, input int per_phase);
      int            a;
      int            b;
      int            lo[3];
      int            hi[3];
      logic [CW-1:0] junk;
      for (int ph = 0; ph < phases; ph++) begin
         junk = CW'({$urandom, $urandom});
         if (ph < 2) begin
            a = (ph == 0) ? VMAX : VMIN;
            csr_write(pfvu_pkg::REG_GRAVITY, pack3(a, a, a));
            csr_write(pfvu_pkg::REG_WIND, pack3(a, a, a));
            csr_write(pfvu_pkg::REG_FIELD, pack3(a, a, a));
            csr_write(pfvu_pkg::REG_BOX_MIN, pack3(VMIN, VMIN, VMIN));
            csr_write(pfvu_pkg::REG_BOX_MAX, pack3(VMAX, VMAX, VMAX));
            csr_write(pfvu_pkg::REG_DRAG,
                      (ph == 0) ? {junk[CW-1:DRW], 16'hFFFF} : CW'(1));
            csr_write(pfvu_pkg::REG_MODE, {junk[CW-1:MW], MODE_ALL});
         end else begin
            csr_write(pfvu_pkg::REG_GRAVITY, pack3(rand_comp(), rand_comp(), rand_comp()));
            csr_write(pfvu_pkg::REG_WIND, pack3(rand_comp(), rand_comp(), rand_comp()));
            csr_write(pfvu_pkg::REG_FIELD, pack3(rand_comp(), rand_comp(), rand_comp()));
            for (int i = 0; i < 3; i++) begin
               a = rand_comp();
               b = rand_comp();
               lo[i] = (a < b) ? a : b;
               hi[i] = (a < b) ? b : a;
               // now and then an inverted axis to empty the box
               if ($urandom_range(0, 7) == 0) begin
                  lo[i] = hi[i] + 1;
                  hi[i] = hi[i] - 1;
               end
            end
            csr_write(pfvu_pkg::REG_BOX_MIN, pack3(lo[0], lo[1], lo[2]));
            csr_write(pfvu_pkg::REG_BOX_MAX, pack3(hi[0], hi[1], hi[2]));
            case ($urandom_range(0, 7))
               0:       junk[DRW-1:0] = '0;
               1:       junk[DRW-1:0] = '1;
               2, 3, 4: junk[DRW-1:0] = DRW'($urandom_range(0, 4096));
               default: junk[DRW-1:0] = DRW'($urandom);
            endcase
            csr_write(pfvu_pkg::REG_DRAG, junk);
            junk = CW'({$urandom, $urandom});
            if ($urandom_range(0, 4) < 3) junk[MW-1:0] = MODE_ALL;
            csr_write(pfvu_pkg::REG_MODE, junk);
            if ($urandom_range(0, 3) == 0) csr_write(REG_UNUSED, CW'({$urandom, $urandom}));
         end
         settings_used++;
         // alternate stretches with and without idling on both sides
         idle_enable = (ph % 3) != 1;
         for (int n = 0; n < per_phase; n++) send_item(rand_particle());
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.vel_x     <= '0;
      req_chan.vel_y     <= '0;
      req_chan.vel_z     <= '0;
      req_chan.pos_x     <= '0;
      req_chan.pos_y     <= '0;
      req_chan.pos_z     <= '0;
      req_chan.time_step <= '0;
      csr_chan.valid     <= 1'b0;
      csr_chan.addr      <= '0;
      csr_chan.data      <= '0;
      force_cfg          = '0;
      idle_enable        = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_disabled_passthrough();
      idle_enable = 1'b1;
      test_gravity_and_wind();
      test_drag_scaling();
      test_field_box();
      test_unknown_register();
      test_random_traffic(8, 75);

      // drain, then give the pipeline time to show any stray response
      wait_idle();
      repeat (PIPE_LAT * 4) @(posedge clock);
      if (pending_velocity_q.size() != 0)
         report_mismatch("outstanding predictions", 0, pending_velocity_q.size());

      $display("%0d particle transactions, %0d responses checked, %0d mismatches",
               items_sent, results_checked, mismatch_count);
      $display("%0d register writes over %0d settings, drag, field box and saturation",
               csr_writes, settings_used);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
